// File: hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and codes
// request and result payloads, classified command and operation codes
// ----------------------------------------------------------------------------
package lkvc_pkg;

    // request opcodes as they arrive on the port
    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam int unsigned FIELD_BITS = 64;
    localparam int unsigned LIMIT_BITS = 5;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [FIELD_BITS-1:0] lookup_key;
        logic [FIELD_BITS-1:0] store_value;
    } t_req;

    typedef struct packed {
        logic                  found;
        logic [FIELD_BITS-1:0] read_value;
        logic                  evicted;
    } t_rsp;

    // classified command handed from the front to the back
    typedef struct packed {
        logic                  is_put;
        logic                  is_get;
        logic                  is_remove;
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] value;
    } t_cmd;

endpackage

// File: hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, lru replacement
// put, get and remove requests over a small table with age ranks per slot
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+--------------------------
//  request   | in        | push, full                | i_req  (opcode, key, value)
//  result    | out       | empty, pop                | o_rsp  (found, value, evicted)
//  config    | in        | i_cfg_wr_en               | i_cfg_wr_data (entry limit)
//
//  a request passes the back end states match, execute and done, plus evict
//  for an eviction and insert for an insertion, stepped by the single-request
//  sequencer in lkvc_back; done waits until the result register can take it
//  the two-entry request queue keeps accepting, until full, while the back end
//  works and the result register waits to be popped
//  reset (synchronous, active low) empties the table, queue and result
//
module lru_key_value_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request side
    input  logic                            push,
    output logic                            full,
    input  lkvc_pkg::t_req                  i_req,
    // result side
    output logic                            empty,
    input  logic                            pop,
    output lkvc_pkg::t_rsp                  o_rsp,
    // entry limit register
    input  logic                            i_cfg_wr_en,
    input  logic [lkvc_pkg::LIMIT_BITS-1:0] i_cfg_wr_data
);

    logic                            r_entry_limit_v;
    logic [lkvc_pkg::LIMIT_BITS-1:0] r_entry_limit;
    logic                            r_out_valid;
    lkvc_pkg::t_rsp                  r_out;

    logic                            cmd_valid;
    logic                            cmd_ready;
    lkvc_pkg::t_cmd                  cmd;
    logic                            rsp_valid;
    logic                            rsp_ready;
    lkvc_pkg::t_rsp                  rsp;

    // entry limit, zero selects full capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_limit   <= '0;
            r_entry_limit_v <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_entry_limit   <= i_cfg_wr_data;
            r_entry_limit_v <= 1'b1;
        end
    end

    // front: decode and queue requests
    lkvc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // back: lookup, rank upkeep, eviction
    lkvc_back #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_entry_limit_v ? r_entry_limit : '0),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    // result register: frees the back end as soon as a result is parked
    assign rsp_ready = !r_out_valid || pop;
    assign empty     = !r_out_valid;
    assign o_rsp     = r_out;

    always_ff @(posedge i_clk) begin
        if (rsp_valid && rsp_ready) begin
            r_out <= rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_valid && rsp_ready) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// File: hdl/lkvc_front.sv
// ----------------------------------------------------------------------------
// lkvc_front: request intake
// decodes each request and holds it in a two-entry queue for the back end
// ----------------------------------------------------------------------------
module lkvc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  lkvc_pkg::t_req  i_req,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output lkvc_pkg::t_cmd  o_cmd
);

    lkvc_pkg::t_cmd r_q [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_level;
    lkvc_pkg::t_cmd cmd_dec;
    logic           wr_fire;
    logic           rd_fire;

    always_comb begin
        cmd_dec           = '0;
        cmd_dec.key       = i_req.lookup_key;
        cmd_dec.value     = i_req.store_value;
        case (i_req.opcode)
            lkvc_pkg::OP_PUT:    cmd_dec.is_put    = 1'b1;
            lkvc_pkg::OP_GET:    cmd_dec.is_get    = 1'b1;
            lkvc_pkg::OP_REMOVE: cmd_dec.is_remove = 1'b1;
            default:             cmd_dec.is_put    = 1'b0;
        endcase
    end

    assign full        = (r_level == 2'd2);
    assign wr_fire     = push && !full;
    assign o_cmd_valid = (r_level != 2'd0);
    assign rd_fire     = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_q[r_wr_ptr] <= cmd_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (wr_fire) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd_fire) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (wr_fire && !rd_fire) begin
                r_level <= r_level + 2'd1;
            end else if (rd_fire && !wr_fire) begin
                r_level <= r_level - 2'd1;
            end
        end
    end

endmodule

// File: hdl/lkvc_back.sv
// ----------------------------------------------------------------------------
// lkvc_back: table and replacement engine
// key match, age rank upkeep, eviction and insertion, one request at a time
// ----------------------------------------------------------------------------
module lkvc_back #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [lkvc_pkg::LIMIT_BITS-1:0] i_limit,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_ready,
    input  lkvc_pkg::t_cmd                  i_cmd,
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_ready,
    output lkvc_pkg::t_rsp                  o_rsp
);

    localparam int IW   = $clog2(ENTRIES);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > lkvc_pkg::LIMIT_BITS) ? CW : lkvc_pkg::LIMIT_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MATCH  = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_EVICT  = 3'd3;
    localparam logic [2:0] ST_INSERT = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]            r_state;
    lkvc_pkg::t_cmd        r_cmd;
    logic [KEY_BITS-1:0]   r_keys [ENTRIES];
    logic [IW-1:0]         r_rank [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic [CW-1:0]         r_count;
    logic [VALUE_BITS-1:0] mem_values [ENTRIES];
    logic [VALUE_BITS-1:0] r_rd_data;
    logic [ENTRIES-1:0]    r_hit_vec;
    logic                  r_found;
    logic [IW-1:0]         r_hit_idx;
    logic [IW-1:0]         r_hit_rank;
    logic                  r_evicted;

    logic [ENTRIES-1:0]    hit_vec;
    logic [IW-1:0]         hit_idx;
    logic [IW-1:0]         hit_rank;
    logic [ENTRIES-1:0]    old_vec;
    logic [IW-1:0]         old_idx;
    logic [IW-1:0]         old_rank;
    logic [IW-1:0]         free_idx;
    logic                  free_ok;
    logic [CMPW-1:0]       lim_eff;
    logic [CMPW-1:0]       count_w;
    logic                  take;
    logic                  mem_we;
    logic [IW-1:0]         mem_addr;

    // parallel key compare and one-hot encode
    always_comb begin
        hit_idx  = '0;
        hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_keys[i] == r_cmd.key[KEY_BITS-1:0]);
            if (hit_vec[i]) begin
                hit_idx  = hit_idx | IW'(i);
                hit_rank = hit_rank | r_rank[i];
            end
        end
    end

    // oldest valid slot holds rank count-1
    always_comb begin
        old_idx  = '0;
        old_rank = IW'(r_count - CW'(1));
        for (int i = 0; i < ENTRIES; i++) begin
            old_vec[i] = r_valid[i] && (r_count != '0) && (r_rank[i] == old_rank);
            if (old_vec[i]) begin
                old_idx = old_idx | IW'(i);
            end
        end
    end

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
        end
        free_ok = ~&r_valid;
    end

    always_comb begin
        count_w = CMPW'(r_count);
        if ((i_limit == '0) || (CMPW'(i_limit) > CMPW'(ENTRIES))) begin
            lim_eff = CMPW'(ENTRIES);
        end else begin
            lim_eff = CMPW'(i_limit);
        end
    end

    assign o_cmd_ready = (r_state == ST_IDLE) || ((r_state == ST_DONE) && i_rsp_ready);
    assign take        = o_cmd_ready && i_cmd_valid;
    assign o_rsp_valid = (r_state == ST_DONE);

    always_comb begin
        o_rsp            = '0;
        o_rsp.found      = r_found && (r_cmd.is_put || r_cmd.is_get || r_cmd.is_remove);
        o_rsp.evicted    = r_evicted;
        if (r_cmd.is_get && r_found) begin
            o_rsp.read_value = lkvc_pkg::FIELD_BITS'(r_rd_data);
        end
    end

    assign mem_we   = ((r_state == ST_EXEC) && r_cmd.is_put && r_found) ||
                      ((r_state == ST_INSERT) && free_ok);
    assign mem_addr = (r_state == ST_EXEC) ? r_hit_idx : free_idx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_values[mem_addr] <= r_cmd.value[VALUE_BITS-1:0];
        end
        r_rd_data <= mem_values[r_hit_idx];
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_MATCH) begin
            r_hit_vec  <= hit_vec;
            r_found    <= |hit_vec;
            r_hit_idx  <= hit_idx;
            r_hit_rank <= hit_rank;
        end
        if ((r_state == ST_INSERT) && free_ok) begin
            r_keys[free_idx] <= r_cmd.key[KEY_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_count   <= '0;
            r_evicted <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        r_evicted <= 1'b0;
                        r_state   <= ST_MATCH;
                    end
                end
                ST_MATCH: begin
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    r_state <= ST_DONE;
                    if ((r_cmd.is_put || r_cmd.is_get) && r_found) begin
                        // touch: newer entries age by one, hit becomes newest
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                                r_rank[i] <= r_rank[i] + IW'(1);
                            end
                        end
                        r_rank[r_hit_idx] <= '0;
                        if (r_cmd.is_put && (count_w > lim_eff)) begin
                            r_state <= ST_EVICT;
                        end
                    end else if (r_cmd.is_put) begin
                        if ((count_w >= lim_eff) && (r_count != '0)) begin
                            r_state <= ST_EVICT;
                        end else begin
                            r_state <= ST_INSERT;
                        end
                    end else if (r_cmd.is_remove && r_found) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (r_valid[i] && (r_rank[i] > r_hit_rank)) begin
                                r_rank[i] <= r_rank[i] - IW'(1);
                            end
                        end
                        r_rank[r_hit_idx]  <= '0;
                        r_valid[r_hit_idx] <= 1'b0;
                        r_count            <= r_count - CW'(1);
                    end
                end
                ST_EVICT: begin
                    // oldest has the top rank, nothing above it to shift
                    if (|old_vec) begin
                        r_evicted          <= 1'b1;
                        r_valid[old_idx]   <= 1'b0;
                        r_rank[old_idx]    <= '0;
                        r_count            <= r_count - CW'(1);
                    end
                    r_state <= r_found ? ST_DONE : ST_INSERT;
                end
                ST_INSERT: begin
                    if (free_ok) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (r_valid[i]) begin
                                r_rank[i] <= r_rank[i] + IW'(1);
                            end
                        end
                        r_rank[free_idx]  <= '0;
                        r_valid[free_idx] <= 1'b1;
                        r_count           <= r_count + CW'(1);
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_rsp_ready) begin
                        if (i_cmd_valid) begin
                            r_evicted <= 1'b0;
                            r_state   <= ST_MATCH;
                        end else begin
                            r_state   <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_count))
        else $error("entry count disagrees with valid slots");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= ENTRIES)
        else $error("entry count above capacity");

    a_keys_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> $onehot0(r_hit_vec))
        else $error("key held in more than one slot");

    a_evict_only_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && r_evicted) |-> r_cmd.is_put)
        else $error("eviction on a request other than put");

    a_insert_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INSERT) |-> free_ok)
        else $error("insert with no free slot");
`endif

endmodule

// File: tb/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: self-checking bench for the lru key-value cache
// drives put, get, remove and unused-opcode requests with random gaps on both sides, keeps
// a shadow table with age ranks to work out each answer, and compares every
// popped result field by field against the oldest answer still owed
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;

    localparam int ENTRIES     = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;
    localparam int SETTLE_CYCLES = 8;

    // dut inputs, all known from time zero
    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            push          = 1'b0;
    logic                            full;
    lkvc_pkg::t_req                  i_req         = '0;
    logic                            empty;
    logic                            pop           = 1'b0;
    lkvc_pkg::t_rsp                  o_rsp;
    logic                            i_cfg_wr_en   = 1'b0;
    logic [lkvc_pkg::LIMIT_BITS-1:0] i_cfg_wr_data = '0;

    // shadow copy of the cache contents and the limit register
    bit [lkvc_pkg::FIELD_BITS-1:0]   slot_key   [ENTRIES];
    bit [lkvc_pkg::FIELD_BITS-1:0]   slot_val   [ENTRIES];
    bit                              slot_valid [ENTRIES];
    int unsigned                     slot_age   [ENTRIES];
    int unsigned                     slot_count;
    logic [lkvc_pkg::LIMIT_BITS-1:0] limit_reg;

    // answers owed by the cache, oldest first
    lkvc_pkg::t_rsp pending_rsps[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  no_idle        = 1'b0;  // both sides run without gaps while set
    int  hold_cycles    = 0;     // one long stall asked of the result side

    lru_key_value_cache #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (lkvc_pkg::FIELD_BITS),
        .VALUE_BITS (lkvc_pkg::FIELD_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_req         (i_req),
        .empty         (empty),
        .pop           (pop),
        .o_rsp         (o_rsp),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // hard stop in case a handshake never completes
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lru_key_value_cache verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // shadow table
    // ------------------------------------------------------------------

    // slot becomes newest, everything that was newer ages by one
    function automatic void make_newest(int s);
        int unsigned r;
        r = slot_age[s];
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_age[i] < r)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    // slot leaves, everything that was older moves up by one
    function automatic void drop_slot(int s);
        int unsigned r;
        r = slot_age[s];
        slot_valid[s] = 1'b0;
        slot_age[s]   = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_age[i] > r)
                slot_age[i]--;
        if (slot_count > 0)
            slot_count--;
    endfunction

    // push out the oldest valid slot other than keep (-1 keeps none)
    function automatic bit evict_oldest(int keep);
        int v;
        v = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && i != keep && (v < 0 || slot_age[i] > slot_age[v]))
                v = i;
        if (v < 0)
            return 1'b0;
        drop_slot(v);
        return 1'b1;
    endfunction

    // apply one request to the shadow table and return the answer it earns
    function automatic lkvc_pkg::t_rsp cache_apply(lkvc_pkg::t_req r);
        lkvc_pkg::t_rsp rsp;
        int             hit;
        int             free_slot;
        int unsigned    cap;
        rsp       = '0;
        hit       = -1;
        free_slot = -1;
        // zero or anything above the table size means the whole table
        cap = (limit_reg == 0 || limit_reg > ENTRIES) ? ENTRIES : limit_reg;
        for (int i = 0; i < ENTRIES; i++)
            if (hit < 0 && slot_valid[i] && slot_key[i] == r.lookup_key)
                hit = i;
        case (r.opcode)
            lkvc_pkg::OP_PUT: begin
                if (hit >= 0) begin
                    rsp.found     = 1'b1;
                    slot_val[hit] = r.store_value;
                    make_newest(hit);
                    // limit may have been lowered: at most one eviction per put
                    if (slot_count > cap)
                        rsp.evicted = evict_oldest(hit);
                end else begin
                    if (slot_count + 1 > cap)
                        rsp.evicted = evict_oldest(-1);
                    for (int i = 0; i < ENTRIES; i++)
                        if (free_slot < 0 && !slot_valid[i])
                            free_slot = i;
                    if (free_slot >= 0) begin
                        for (int j = 0; j < ENTRIES; j++)
                            if (slot_valid[j])
                                slot_age[j]++;
                        slot_valid[free_slot] = 1'b1;
                        slot_key[free_slot]   = r.lookup_key;
                        slot_val[free_slot]   = r.store_value;
                        slot_age[free_slot]   = 0;
                        slot_count++;
                    end
                end
            end
            lkvc_pkg::OP_GET: begin
                if (hit >= 0) begin
                    rsp.found      = 1'b1;
                    rsp.read_value = slot_val[hit];
                    make_newest(hit);
                end
            end
            lkvc_pkg::OP_REMOVE: begin
                if (hit >= 0) begin
                    rsp.found = 1'b1;
                    drop_slot(hit);
                end
            end
            default: begin
                // unused opcode: all result fields stay zero
            end
        endcase
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    function automatic int draw_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    // random 64-bit word, with the extremes turning up now and then
    function automatic logic [lkvc_pkg::FIELD_BITS-1:0] rand_word();
        int pick;
        pick = $urandom_range(0, 11);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {$urandom(), $urandom()};
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 60)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // offer one request until it is taken, then record what it should return;
    // push stays high when the next request follows with no gap
    task automatic push_request(input lkvc_pkg::t_req r);
        int gap;
        push  <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (full);
        pending_rsps.push_back(cache_apply(r));
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every answer owed has been popped
    task automatic drain_requests();
        push <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // limit register is only touched with the cache idle
    task automatic set_entry_limit(input logic [lkvc_pkg::LIMIT_BITS-1:0] lim);
        drain_requests();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= lim;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        limit_reg = lim;
    endtask

    task automatic send_op(input logic [1:0] op,
                           input logic [lkvc_pkg::FIELD_BITS-1:0] k,
                           input logic [lkvc_pkg::FIELD_BITS-1:0] v);
        lkvc_pkg::t_req r;
        r.opcode      = op;
        r.lookup_key  = k;
        r.store_value = v;
        push_request(r);
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, one long hold when asked, checks each pop
    // ------------------------------------------------------------------
    initial begin : result_side
        int             stall;
        lkvc_pkg::t_rsp want;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_gap();
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (pending_rsps.size() == 0) begin
                flag_mismatch("result popped with no request outstanding");
            end else begin
                want = pending_rsps.pop_front();
                if (o_rsp.found !== want.found)
                    flag_mismatch($sformatf("found %b, want %b", o_rsp.found, want.found));
                if (o_rsp.read_value !== want.read_value)
                    flag_mismatch($sformatf("read_value %h, want %h",
                                            o_rsp.read_value, want.read_value));
                if (o_rsp.evicted !== want.evicted)
                    flag_mismatch($sformatf("evicted %b, want %b",
                                            o_rsp.evicted, want.evicted));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every operation at least once, misses, overwrite, extreme keys and values
    task automatic test_basic_ops();
        set_entry_limit(5'd0);
        send_op(lkvc_pkg::OP_GET,    '0, '1);                   // miss on empty table
        send_op(lkvc_pkg::OP_PUT,    '0, '1);
        send_op(lkvc_pkg::OP_PUT,    '1, '0);
        send_op(lkvc_pkg::OP_GET,    '0, '0);                   // hit, all-ones value
        send_op(lkvc_pkg::OP_PUT,    '0, 64'h5555_aaaa_5555_aaaa); // overwrite, found
        send_op(lkvc_pkg::OP_REMOVE, '1, '1);                   // hit
        send_op(lkvc_pkg::OP_REMOVE, '1, '1);                   // miss
        send_op(lkvc_pkg::OP_NONE,   '1, '1);                   // ignored, all zero
    endtask

    // limit above the table size: a full table still evicts on a new key
    task automatic test_full_table();
        set_entry_limit(5'd31);
        for (int i = 0; i < ENTRIES; i++)
            send_op(lkvc_pkg::OP_PUT, {$urandom(), $urandom()}, rand_word());
        send_op(lkvc_pkg::OP_GET, '0, '0);  // oldest entry, pushed out above
    endtask

    // limit dropped under the count: one eviction per put, gets never evict
    task automatic test_limit_lowered();
        set_entry_limit(5'd1);
        send_op(lkvc_pkg::OP_GET, '1, '0);
        send_op(lkvc_pkg::OP_PUT, {$urandom(), $urandom()}, '1);
        send_op(lkvc_pkg::OP_PUT, '1, '1);
    endtask

    // random mix over a key pool a bit larger than the usable table
    task automatic test_random_mix(input logic [lkvc_pkg::LIMIT_BITS-1:0] lim,
                                   input int n_reqs);
        logic [lkvc_pkg::FIELD_BITS-1:0] key_pool[$];
        int unsigned                     usable;
        int unsigned                     pool_n;
        int                              sent;
        int                              pick;
        lkvc_pkg::t_req                  r;
        set_entry_limit(lim);
        usable = (lim == 0 || lim > ENTRIES) ? ENTRIES : lim;
        pool_n = usable + 1 + $urandom_range(0, usable);
        repeat (pool_n) key_pool.push_back({$urandom(), $urandom()});
        sent = 0;
        while (sent < n_reqs) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                r.opcode = lkvc_pkg::OP_PUT;
            else if (pick < 75)
                r.opcode = lkvc_pkg::OP_GET;
            else if (pick < 95)
                r.opcode = lkvc_pkg::OP_REMOVE;
            else
                r.opcode = lkvc_pkg::OP_NONE;
            if ($urandom_range(0, 9) == 0)
                r.lookup_key = rand_word();
            else
                r.lookup_key = key_pool[$urandom_range(0, pool_n - 1)];
            r.store_value = rand_word();
            push_request(r);
            if (r.opcode != lkvc_pkg::OP_NONE)
                sent++;
        end
    endtask

    // result side holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        set_entry_limit(5'd16);
        hold_cycles = 80;
        no_idle     = 1'b1;
        for (int i = 0; i < 30; i++)
            send_op(($urandom_range(0, 1) == 0) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET,
                    {60'd0, 4'($urandom_range(0, 11))}, rand_word());
        no_idle = 1'b0;
    endtask

    initial begin : stimulus
        limit_reg  = '0;
        slot_count = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_full_table();
        test_limit_lowered();
        test_random_mix(5'd0, 150);
        test_random_mix(5'd1, 150);
        no_idle = 1'b1;
        test_random_mix(5'd2, 150);
        no_idle = 1'b0;
        test_random_mix(5'd31, 150);
        test_random_mix(5'd16, 150);
        test_random_mix(5'd5, 150);    // lowered under a full table
        test_backpressure();
        test_random_mix(5'd17, 150);
        test_random_mix(5'd8, 150);

        drain_requests();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_rsps.size() == 0)
            $display("lru_key_value_cache verification clean");
        else
            $display("lru_key_value_cache verification failed");
        $finish;
    end

endmodule
